[hdl/rgbhsv_pkg.sv]
// rgbhsv_pkg: widths, sector codes and defaults for the rgb to hsv converter
// no dependencies; imported by hdl/rgb_to_hsv_converter.sv and tb/sv/testbench.sv

package rgbhsv_pkg;

    // pixel channel and result field widths
    localparam int unsigned CHAN_W = 8;
    localparam int unsigned HUE_W  = 16;
    localparam int unsigned SAT_W  = 8;

    // default hue resolution in bits per full turn
    localparam int unsigned HUE_BITS_DEF = 16;

    // hue divider: numerator and divisor stay below 6*255+1
    localparam int unsigned HUE_DEN_W = 11;
    // saturation divider: delta*510 + max and 2*max
    localparam int unsigned SAT_NUM_W = 17;
    localparam int unsigned SAT_DEN_W = CHAN_W + 1;

    // packed stream widths
    localparam int unsigned S_TDATA_W = 3 * CHAN_W;
    localparam int unsigned M_TDATA_W = HUE_W + SAT_W + CHAN_W;

    // which channel holds the maximum
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } sector_t;

endpackage

[hdl/rgb_to_hsv_converter.sv]
// rgb_to_hsv_converter: pipelined rgb to hsv conversion, one pixel per clock when not stalled
// a request passes stage 1, stage 2, the stage 3 operand register, the divider stages and the
// output register, after waiting in the input skid register if it was parked there.
// throughput: one pixel per clock when not stalled; hue divider sets depth, one quotient bit per stage.
// reset (aresetn low, synchronous) clears all valid bits and the skid register; data is not reset.
// depends on hdl/rgbhsv_pkg.sv

module rgb_to_hsv_converter #(
    parameter int unsigned HUE_BITS = rgbhsv_pkg::HUE_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // request side
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rgbhsv_pkg::S_TDATA_W-1:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    // result side
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rgbhsv_pkg::M_TDATA_W-1:0] m_tdata    // hue [15:0], saturation [23:16], value [31:24]
);

    import rgbhsv_pkg::*;

    // ------------------------------------------------------------------
    // stall control: every stage moves together unless the output is full
    // and not being taken
    // ------------------------------------------------------------------
    logic pipe_en;

    // input skid register keeps s_tready free of any path from m_tready
    logic                 skid_valid_reg;
    logic [S_TDATA_W-1:0] skid_data_reg;

    logic                 in_valid;
    logic [S_TDATA_W-1:0] in_data;

    logic out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    assign pipe_en  = ~out_valid_reg | m_tready;
    assign s_tready = ~skid_valid_reg;
    assign in_valid = skid_valid_reg | s_tvalid;
    assign in_data  = skid_valid_reg ? skid_data_reg : s_tdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            // skid drains into the first stage, or a fresh request goes straight in
            skid_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!pipe_en && s_tvalid && s_tready) begin
            skid_data_reg <= s_tdata;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: find max, min, the sector and the in-sector difference
    // ------------------------------------------------------------------
    logic [CHAN_W-1:0] in_red, in_green, in_blue;
    logic              red_is_max, green_ge_blue, red_is_min, green_le_blue;
    sector_t           sector_next;
    logic [CHAN_W-1:0] max_next, min_next;
    logic signed [CHAN_W:0] diff_next;

    assign in_red   = in_data[CHAN_W-1:0];
    assign in_green = in_data[2*CHAN_W-1:CHAN_W];
    assign in_blue  = in_data[3*CHAN_W-1:2*CHAN_W];

    assign red_is_max    = (in_red >= in_green) && (in_red >= in_blue);
    assign green_ge_blue = in_green >= in_blue;
    assign red_is_min    = (in_red <= in_green) && (in_red <= in_blue);
    assign green_le_blue = in_green <= in_blue;

    always_comb begin
        // ties: red beats green, green beats blue
        if (red_is_max) begin
            sector_next = SEC_RED;
        end else if (green_ge_blue) begin
            sector_next = SEC_GREEN;
        end else begin
            sector_next = SEC_BLUE;
        end
    end

    always_comb begin
        max_next = red_is_max ? in_red : (green_ge_blue ? in_green : in_blue);
        min_next = red_is_min ? in_red : (green_le_blue ? in_green : in_blue);
    end

    always_comb begin
        unique case (sector_next)
            SEC_RED:   diff_next = $signed({1'b0, in_green}) - $signed({1'b0, in_blue});
            SEC_GREEN: diff_next = $signed({1'b0, in_blue}) - $signed({1'b0, in_red});
            SEC_BLUE:  diff_next = $signed({1'b0, in_red}) - $signed({1'b0, in_green});
            default:   diff_next = '0;
        endcase
    end

    logic                   p1_valid_reg;
    sector_t                p1_sector_reg;
    logic [CHAN_W-1:0]      p1_max_reg;
    logic [CHAN_W-1:0]      p1_min_reg;
    logic signed [CHAN_W:0] p1_diff_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            p1_sector_reg <= sector_next;
            p1_max_reg    <= max_next;
            p1_min_reg    <= min_next;
            p1_diff_reg   <= diff_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: chroma (delta = max - min)
    // ------------------------------------------------------------------
    logic                   p2_valid_reg;
    sector_t                p2_sector_reg;
    logic [CHAN_W-1:0]      p2_max_reg;
    logic [CHAN_W-1:0]      p2_delta_reg;
    logic signed [CHAN_W:0] p2_diff_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            p2_sector_reg <= p1_sector_reg;
            p2_max_reg    <= p1_max_reg;
            p2_delta_reg  <= p1_max_reg - p1_min_reg;
            p2_diff_reg   <= p1_diff_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: divider operands
    //   hue: (offset*delta + diff) / (6*delta), wrapped by one turn if negative
    //   saturation: (delta*510 + max) / (2*max), i.e. rounded to nearest
    // ------------------------------------------------------------------
    logic [HUE_DEN_W-1:0]    delta2, delta4, delta6, hue_base;
    logic signed [HUE_DEN_W+1:0] num_sum, num_wrap;
    logic [SAT_NUM_W-1:0]    sat_num_next;

    assign delta2 = HUE_DEN_W'({p2_delta_reg, 1'b0});
    assign delta4 = HUE_DEN_W'({p2_delta_reg, 2'b00});
    assign delta6 = delta2 + delta4;

    always_comb begin
        unique case (p2_sector_reg)
            SEC_RED:   hue_base = '0;
            SEC_GREEN: hue_base = delta2;
            SEC_BLUE:  hue_base = delta4;
            default:   hue_base = '0;
        endcase
    end

    assign num_sum  = $signed({2'b00, hue_base}) + (HUE_DEN_W+2)'(p2_diff_reg);
    // only the red sector can go negative; add one full turn
    assign num_wrap = num_sum[HUE_DEN_W+1] ? num_sum + $signed({2'b00, delta6}) : num_sum;

    assign sat_num_next = SAT_NUM_W'({p2_delta_reg, 9'b0}) - SAT_NUM_W'({p2_delta_reg, 1'b0})
                        + SAT_NUM_W'(p2_max_reg);

    // divider pipeline, index 0 is the stage 3 register, index k+1 follows k
    logic [HUE_BITS:0]    dv_valid_reg;
    logic [HUE_DEN_W-1:0] dv_hrem_reg  [HUE_BITS+1];
    logic [HUE_DEN_W-1:0] dv_hden_reg  [HUE_BITS+1];
    logic [HUE_BITS-1:0]  dv_hq_reg    [HUE_BITS+1];
    logic [SAT_NUM_W-1:0] dv_srem_reg  [HUE_BITS+1];
    logic [SAT_DEN_W-1:0] dv_sden_reg  [HUE_BITS+1];
    logic [SAT_W-1:0]     dv_sq_reg    [HUE_BITS+1];
    logic [CHAN_W-1:0]    dv_val_reg   [HUE_BITS+1];
    logic [HUE_BITS:0]    dv_grey_reg;
    logic [HUE_BITS:0]    dv_black_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            dv_hrem_reg[0]  <= num_wrap[HUE_DEN_W-1:0];
            dv_hden_reg[0]  <= delta6;
            dv_hq_reg[0]    <= '0;
            dv_srem_reg[0]  <= sat_num_next;
            dv_sden_reg[0]  <= {p2_max_reg, 1'b0};
            dv_sq_reg[0]    <= '0;
            dv_val_reg[0]   <= p2_max_reg;
            dv_grey_reg[0]  <= (p2_delta_reg == '0);
            dv_black_reg[0] <= (p2_max_reg == '0);
        end
    end

    // ------------------------------------------------------------------
    // divider stages: one restoring step per stage for hue, and for the
    // first SAT_W stages also one step for saturation
    // ------------------------------------------------------------------
    for (genvar k = 0; k < HUE_BITS; k++) begin : g_div
        logic [HUE_DEN_W:0] hshift;
        logic [HUE_DEN_W:0] hdiff;
        logic               hbit;

        assign hshift = {dv_hrem_reg[k], 1'b0};
        assign hdiff  = hshift - {1'b0, dv_hden_reg[k]};
        assign hbit   = hshift >= {1'b0, dv_hden_reg[k]};

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                dv_hrem_reg[k+1]  <= hbit ? hdiff[HUE_DEN_W-1:0] : hshift[HUE_DEN_W-1:0];
                dv_hden_reg[k+1]  <= dv_hden_reg[k];
                dv_hq_reg[k+1]    <= {dv_hq_reg[k][HUE_BITS-2:0], hbit};
                dv_sden_reg[k+1]  <= dv_sden_reg[k];
                dv_val_reg[k+1]   <= dv_val_reg[k];
                dv_grey_reg[k+1]  <= dv_grey_reg[k];
                dv_black_reg[k+1] <= dv_black_reg[k];
            end
        end

        if (k < SAT_W) begin : g_sat
            logic [SAT_NUM_W-1:0] sden_sh;
            logic                 sbit;

            // divisor lined up with quotient bit SAT_W-1-k
            assign sden_sh = SAT_NUM_W'(dv_sden_reg[k]) << (SAT_W - 1 - k);
            assign sbit    = dv_srem_reg[k] >= sden_sh;

            always_ff @(posedge aclk) begin
                if (pipe_en) begin
                    dv_srem_reg[k+1] <= sbit ? dv_srem_reg[k] - sden_sh : dv_srem_reg[k];
                    dv_sq_reg[k+1]   <= {dv_sq_reg[k][SAT_W-2:0], sbit};
                end
            end
        end else begin : g_sat_pass
            always_ff @(posedge aclk) begin
                if (pipe_en) begin
                    dv_srem_reg[k+1] <= dv_srem_reg[k];
                    dv_sq_reg[k+1]   <= dv_sq_reg[k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            dv_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            p1_valid_reg  <= in_valid;
            p2_valid_reg  <= p1_valid_reg;
            dv_valid_reg  <= {dv_valid_reg[HUE_BITS-1:0], p2_valid_reg};
            out_valid_reg <= dv_valid_reg[HUE_BITS];
        end
    end

    // ------------------------------------------------------------------
    // output register: grey forces hue to 0, black forces saturation to 0;
    // hue keeps its low 16 bits, or is zero-extended when narrower
    // ------------------------------------------------------------------
    logic [HUE_BITS+HUE_W-1:0] hue_ext;
    logic [HUE_W-1:0]          hue_next;
    logic [SAT_W-1:0]          sat_next;

    assign hue_ext  = {HUE_W'(0), dv_hq_reg[HUE_BITS]};
    assign hue_next = dv_grey_reg[HUE_BITS] ? '0 : hue_ext[HUE_W-1:0];
    assign sat_next = dv_black_reg[HUE_BITS] ? '0 : dv_sq_reg[HUE_BITS];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            out_data_reg <= {dv_val_reg[HUE_BITS], sat_next, hue_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a request taken during a stall must be parked in the skid register
    a_skid_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !pipe_en) |=> skid_valid_reg)
        else $error("request lost during stall");

    // a parked request stays put while the pipeline is stalled
    a_skid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !pipe_en) |=> (skid_valid_reg && $stable(skid_data_reg)))
        else $error("skid register changed during stall");

    // stalled pipeline keeps its divider valid bits
    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(dv_valid_reg))
        else $error("divider valid bits moved during stall");

    // black pixel gives all-zero hue and saturation
    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[M_TDATA_W-1:HUE_W+SAT_W] == '0)) |-> (m_tdata[HUE_W+SAT_W-1:0] == '0))
        else $error("black pixel with non-zero hue or saturation");

    // zero saturation only for grey, so hue must be zero too
    a_grey: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[HUE_W+SAT_W-1:HUE_W] == '0)) |-> (m_tdata[HUE_W-1:0] == '0))
        else $error("grey pixel with non-zero hue");

endmodule

[tb/sv/testbench.sv]
// testbench: self-checking bench for the rgb to hsv converter, directed pixels then random ones
// needs hdl/rgbhsv_pkg.sv and hdl/rgb_to_hsv_converter.sv; compares every result with a hand-worked or predicted hsv

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbhsv_pkg::*;

    // bench constants
    localparam int unsigned N_DIRECTED  = 23;
    localparam int unsigned RANDOM_EACH = 375;    // random pixels per idling phase
    localparam int unsigned DRAIN_WAIT  = HUE_BITS_DEF + 3 + 16;
    localparam int unsigned MAX_SHOWN   = 10;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [SAT_W-1:0]  saturation;
        logic [CHAN_W-1:0] value;
    } hsv_t;

    // one directed pixel; known rows carry a hand-worked result
    typedef struct {
        pixel_t px;
        logic   known;
        hsv_t   hsv;
    } pixel_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;    // red [7:0], green [15:8], blue [23:16]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // hue [15:0], saturation [23:16], value [31:24]

    // results still owed by the block, oldest first
    hsv_t pending_hsv[$];
    int   error_count   = 0;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;

    pixel_row_t directed_rows [N_DIRECTED] = '{
        // black, greys and white: no hue, no saturation
        '{'{8'd0,   8'd0,   8'd0  }, 1'b1, '{16'd0,     8'd0,   8'd0  }},
        '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{16'd0,     8'd0,   8'd255}},
        '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{16'd0,     8'd0,   8'd128}},
        '{'{8'd1,   8'd1,   8'd1  }, 1'b1, '{16'd0,     8'd0,   8'd1  }},
        // primaries sit at 0, 1/3 and 2/3 of a turn
        '{'{8'd255, 8'd0,   8'd0  }, 1'b1, '{16'd0,     8'd255, 8'd255}},
        '{'{8'd0,   8'd255, 8'd0  }, 1'b1, '{16'd21845, 8'd255, 8'd255}},
        '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{16'd43690, 8'd255, 8'd255}},
        // tied maxima: red beats green and blue, green beats blue
        '{'{8'd255, 8'd255, 8'd0  }, 1'b1, '{16'd10922, 8'd255, 8'd255}},
        '{'{8'd0,   8'd255, 8'd255}, 1'b1, '{16'd32768, 8'd255, 8'd255}},
        '{'{8'd255, 8'd0,   8'd255}, 1'b1, '{16'd54613, 8'd255, 8'd255}},
        // red sector wrapping just below a full turn
        '{'{8'd255, 8'd0,   8'd1  }, 1'b0, '0},
        // smallest spreads and near-tied maxima
        '{'{8'd1,   8'd0,   8'd0  }, 1'b0, '0},
        '{'{8'd0,   8'd0,   8'd1  }, 1'b0, '0},
        '{'{8'd0,   8'd1,   8'd1  }, 1'b0, '0},
        '{'{8'd254, 8'd255, 8'd255}, 1'b0, '0},
        '{'{8'd255, 8'd255, 8'd254}, 1'b0, '0},
        '{'{8'd255, 8'd254, 8'd0  }, 1'b0, '0},
        '{'{8'd255, 8'd0,   8'd254}, 1'b0, '0},
        // ordinary colours in every sector
        '{'{8'd200, 8'd100, 8'd100}, 1'b0, '0},
        '{'{8'd128, 8'd64,  8'd200}, 1'b0, '0},
        '{'{8'd100, 8'd200, 8'd150}, 1'b0, '0},
        '{'{8'd50,  8'd50,  8'd255}, 1'b0, '0},
        '{'{8'd170, 8'd85,  8'd0  }, 1'b0, '0}
    };

    rgb_to_hsv_converter #(
        .HUE_BITS (HUE_BITS_DEF)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // hsv of one pixel: value is the top channel, hue counted in sixths of a turn
    function automatic hsv_t hsv_of_pixel(pixel_t px);
        hsv_t            res;
        int unsigned     r, g, b, top, bottom, spread, num;
        sector_t         sec;
        longint unsigned turn;
        r      = px.red;
        g      = px.green;
        b      = px.blue;
        top    = (r > g) ? r : g;
        top    = (top > b) ? top : b;
        bottom = (r < g) ? r : g;
        bottom = (bottom < b) ? bottom : b;
        spread = top - bottom;
        res    = '0;
        res.value = top[CHAN_W-1:0];
        // rounded to nearest, halves up
        if (top != 0) begin
            res.saturation = SAT_W'((spread * 510 + top) / (2 * top));
        end
        if (spread != 0) begin
            if (r == top) begin
                sec = SEC_RED;
            end else if (g == top) begin
                sec = SEC_GREEN;
            end else begin
                sec = SEC_BLUE;
            end
            case (sec)
                SEC_RED: begin
                    // below zero wraps round by one full turn
                    num = (g >= b) ? g - b : 6 * spread - (b - g);
                end
                SEC_GREEN: begin
                    num = 2 * spread + b - r;
                end
                default: begin
                    num = 4 * spread + r - g;
                end
            endcase
            turn    = num;
            turn    = (turn << HUE_BITS_DEF) / (6 * spread);
            res.hue = turn[HUE_W-1:0];
        end
        return res;
    endfunction

    task automatic flag_error(string msg);
        error_count++;
        if (error_count <= MAX_SHOWN) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // one pixel request, with random idle cycles ahead of it
    task automatic send_pixel(pixel_t px, logic known, hsv_t hand_hsv);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {px.blue, px.green, px.red};
        do @(posedge aclk); while (!s_tready);
        pending_hsv.push_back(known ? hand_hsv : hsv_of_pixel(px));
    endtask

    // random pixel, biased towards greys, ties, narrow spreads and extremes
    function automatic pixel_t random_pixel();
        pixel_t px;
        int     shade;
        px = pixel_t'($urandom);
        case ($urandom_range(7))
            4: begin
                px.green = px.red;
                px.blue  = px.red;
            end
            5: begin
                // two channels share the top
                px.green = px.red;
                shade    = $urandom_range(px.red);
                case ($urandom_range(2))
                    0: px.blue = CHAN_W'(shade);
                    1: begin
                        px.blue  = px.red;
                        px.green = CHAN_W'(shade);
                    end
                    default: begin
                        px.blue = px.red;
                        px.red  = CHAN_W'(shade);
                    end
                endcase
            end
            6: begin
                // spread of at most two
                shade    = $urandom_range(253);
                px.red   = CHAN_W'(shade + $urandom_range(2));
                px.green = CHAN_W'(shade + $urandom_range(2));
                px.blue  = CHAN_W'(shade + $urandom_range(2));
            end
            7: begin
                if ($urandom_range(2) == 0) px.red   = $urandom_range(1) ? 8'd255 : 8'd0;
                if ($urandom_range(2) == 0) px.green = $urandom_range(1) ? 8'd255 : 8'd0;
                if ($urandom_range(2) == 0) px.blue  = $urandom_range(1) ? 8'd255 : 8'd0;
            end
            default: ;
        endcase
        return px;
    endfunction

    // result side back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // result checker, oldest expectation first
    always @(posedge aclk) begin
        hsv_t got;
        hsv_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[15:0], m_tdata[23:16], m_tdata[31:24]};
            if (pending_hsv.size() == 0) begin
                flag_error($sformatf("unexpected result hue %0d sat %0d val %0d",
                                     got.hue, got.saturation, got.value));
            end else begin
                want = pending_hsv.pop_front();
                if (got.hue != want.hue || got.saturation != want.saturation ||
                    got.value != want.value) begin
                    flag_error($sformatf(
                        "hsv wrong: expected %0d/%0d/%0d, got %0d/%0d/%0d (hue/sat/val)",
                        want.hue, want.saturation, want.value,
                        got.hue, got.saturation, got.value));
                end
            end
        end
    end

    // reset, then four idling phases: none, sender idle, receiver stall, both
    initial begin
        int idle_by_phase  [4] = '{0, 79, 0, 33};
        int stall_by_phase [4] = '{0, 0, 79, 33};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_pixel(directed_rows[i].px, directed_rows[i].known, directed_rows[i].hsv);
        end
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_by_phase[ph];
            stall_pct     = stall_by_phase[ph];
            for (int n = 0; n < RANDOM_EACH; n++) begin
                send_pixel(random_pixel(), 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;
        while (pending_hsv.size() != 0) @(posedge aclk);
        // catch any stray result after the last one owed
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (pending_hsv.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", pending_hsv.size()));
        end
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
hdl/rgbhsv_pkg.sv
hdl/rgb_to_hsv_converter.sv
tb/sv/testbench.sv
